// ----- rtl/core/mrp_pkg.sv -----
package mrp_pkg;

	localparam int POS_W = 9;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  EXC_BIT  = 8'h80;

	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_EXCEPT   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN  = 3'd3;
	localparam logic [2:0] ST_CRC_ERR  = 3'd4;

	localparam logic RK_WORD   = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	typedef struct packed {
		logic en;       // a byte is processed this cycle
		logic feed;     // delayed byte goes into the crc
		logic restart;  // end of frame, back to init
	} crc_ctl_t;

	// one byte of crc-16/modbus, reflected, unrolled over the eight bits
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/modbus_rtu_response_parser.sv -----
// channel   signals                                   moves
// rx        rx_valid, rx_stall, rx_byte, frame_last   one frame byte per transfer
// res       res_valid, res_stall, result_kind,        one register word or one
//           word_index, word_value, slave_address,    end-of-frame status per
//           function_code, frame_status,              transfer
//           exception_code
//
// one byte per cycle while rx_stall is low: a byte sits in the input
// register, then the parse, the crc step and the status decision update
// the result register. the output register lets the next byte enter while
// a result still waits.
// arst_n clears the frame state; res_stall holds the result and, once the
// input register is also full, raises rx_stall.
module modbus_rtu_response_parser
	import mrp_pkg::*;
#(
	parameter int FRAME_LIMIT = 256
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        result_kind,
	output logic [6:0]  word_index,
	output logic [15:0] word_value,
	output logic [7:0]  slave_address,
	output logic [7:0]  function_code,
	output logic [2:0]  frame_status,
	output logic [7:0]  exception_code
);

	localparam logic [POS_W-1:0] LIMIT = POS_W'(FRAME_LIMIT);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [POS_W-1:0] pos_q;
	logic [7:0]  addr_q;
	logic [7:0]  func_q;
	logic [7:0]  count_q;
	logic [7:0]  high_q;
	logic [7:0]  exc_q;

	logic        res_valid_q;
	logic        kind_q;
	logic [6:0]  widx_q;
	logic [15:0] wval_q;
	logic [7:0]  addr_out_q;
	logic [7:0]  func_out_q;
	logic [2:0]  status_q;
	logic [7:0]  exc_out_q;

	logic        out_free;
	logic        advance;
	logic [7:0]  addr_n;
	logic [7:0]  func_n;
	logic [7:0]  count_n;
	logic [7:0]  exc_n;
	logic        word_out;
	logic [POS_W-1:0] half_pos;
	logic [6:0]  widx;
	logic [2:0]  status;
	logic        below_limit;
	logic        is_read;
	logic        is_write;
	logic [POS_W:0] need_pos;
	crc_ctl_t    crc_ctl;
	logic [15:0] crc_next;
	logic [7:0]  crc_low;

	assign out_free = !res_valid_q || !res_stall;
	assign advance  = valid_s1 && out_free;
	assign rx_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
			last_s1 <= frame_last;
		end
	end

	// header bytes take effect in the same step they arrive
	assign addr_n  = (pos_q == POS_W'(0)) ? byte_s1 : addr_q;
	assign func_n  = (pos_q == POS_W'(1)) ? byte_s1 : func_q;
	assign count_n = (pos_q == POS_W'(2)) ? byte_s1 : count_q;
	assign exc_n   = (pos_q == POS_W'(2)) ? byte_s1 : exc_q;

	assign below_limit = pos_q < LIMIT;
	assign is_read     = func_n == FC_READ_HOLDING;
	assign is_write    = (func_n == FC_WRITE_SINGLE) || (func_n == FC_WRITE_MULTI);
	assign half_pos    = (pos_q - POS_W'(4)) >> 1;
	assign need_pos    = (POS_W+1)'(count_n) + (POS_W+1)'(4);

	always_comb begin
		word_out = 1'b0;
		widx     = 7'd0;
		if (below_limit && pos_q >= POS_W'(3) && (func_n & EXC_BIT) == 8'h00) begin
			if (is_read) begin
				if (pos_q >= POS_W'(4) && !pos_q[0]
						&& half_pos < POS_W'(count_n >> 1)) begin
					word_out = 1'b1;
					widx     = half_pos[6:0];
				end
			end else if (is_write) begin
				if (pos_q == POS_W'(3)) begin
					word_out = 1'b1;
					widx     = 7'd0;
				end else if (pos_q == POS_W'(5)) begin
					word_out = 1'b1;
					widx     = 7'd1;
				end
			end
		end
	end

	always_comb begin
		priority if (!below_limit) begin
			status = ST_CRC_ERR;
		end else if (pos_q < POS_W'(4)) begin
			status = ST_SHORT;
		end else if ((func_n & EXC_BIT) != 8'h00) begin
			status = ST_EXCEPT;
		end else if (is_read && {1'b0, pos_q} < need_pos) begin
			status = ST_SHORT;
		end else if (is_write && pos_q < POS_W'(6)) begin
			status = ST_SHORT;
		end else if (!is_read && !is_write) begin
			status = ST_UNKNOWN;
		end else if (crc_next != {byte_s1, crc_low}) begin
			status = ST_CRC_ERR;
		end else begin
			status = ST_OK;
		end
	end

	assign crc_ctl = '{en: advance, feed: pos_q >= POS_W'(2), restart: last_s1};

	mrp_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.data      (byte_s1),
		.crc_next  (crc_next),
		.last_byte (crc_low)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			addr_q  <= 8'h00;
			func_q  <= 8'h00;
			count_q <= 8'h00;
			high_q  <= 8'h00;
			exc_q   <= 8'h00;
		end else if (advance) begin
			if (last_s1) begin
				pos_q   <= '0;
				addr_q  <= 8'h00;
				func_q  <= 8'h00;
				count_q <= 8'h00;
				high_q  <= 8'h00;
				exc_q   <= 8'h00;
			end else begin
				if (below_limit) begin
					pos_q <= pos_q + POS_W'(1);
				end
				addr_q  <= addr_n;
				func_q  <= func_n;
				count_q <= count_n;
				high_q  <= byte_s1;
				exc_q   <= exc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && (last_s1 || word_out);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (last_s1 || word_out)) begin
			addr_out_q <= addr_n;
			func_out_q <= func_n;
			if (last_s1) begin
				kind_q    <= RK_STATUS;
				widx_q    <= 7'd0;
				wval_q    <= 16'h0000;
				status_q  <= status;
				exc_out_q <= (status == ST_EXCEPT) ? exc_n : 8'h00;
			end else begin
				kind_q    <= RK_WORD;
				widx_q    <= widx;
				wval_q    <= {high_q, byte_s1};
				status_q  <= ST_OK;
				exc_out_q <= 8'h00;
			end
		end
	end

	assign res_valid      = res_valid_q;
	assign result_kind    = kind_q;
	assign word_index     = widx_q;
	assign word_value     = wval_q;
	assign slave_address  = addr_out_q;
	assign function_code  = func_out_q;
	assign frame_status   = status_q;
	assign exception_code = exc_out_q;

endmodule

// ----- rtl/core/mrp_crc.sv -----
module mrp_crc
	import mrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctl_t    ctl,
	input  logic [7:0]  data,
	output logic [15:0] crc_next,
	output logic [7:0]  last_byte
);

	logic [15:0] crc_q;
	logic [7:0]  dly0_q;
	logic [7:0]  dly1_q;

	// the two newest bytes wait in the delay line so the trailing crc is never fed
	assign crc_next  = ctl.feed ? crc16_byte(crc_q, dly1_q) : crc_q;
	assign last_byte = dly0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			dly0_q <= 8'h00;
			dly1_q <= 8'h00;
		end else if (ctl.en) begin
			if (ctl.restart) begin
				crc_q  <= CRC_INIT;
				dly0_q <= 8'h00;
				dly1_q <= 8'h00;
			end else begin
				crc_q  <= crc_next;
				dly1_q <= dly0_q;
				dly0_q <= data;
			end
		end
	end

endmodule

// ----- verif/tb_modbus_rtu_response_parser.sv -----
module tb_modbus_rtu_response_parser
	import mrp_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LIMIT = 256;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BYTES = 280;   // per idling phase, four phases

	typedef struct packed {
		logic        kind;
		logic [6:0]  index;
		logic [15:0] value;
		logic [7:0]  addr;
		logic [7:0]  fcode;
		logic [2:0]  status;
		logic [7:0]  exc;
	} parse_result_t;

	typedef logic [7:0] frame_bytes_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_last = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        result_kind;
	logic [6:0]  word_index;
	logic [15:0] word_value;
	logic [7:0]  slave_address;
	logic [7:0]  function_code;
	logic [2:0]  frame_status;
	logic [7:0]  exception_code;

	modbus_rtu_response_parser #(.FRAME_LIMIT(FRAME_LIMIT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.frame_last(frame_last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.result_kind(result_kind),
		.word_index(word_index),
		.word_value(word_value),
		.slave_address(slave_address),
		.function_code(function_code),
		.frame_status(frame_status),
		.exception_code(exception_code)
	);

	always #5 clk = ~clk;

	// parser state as the predictor sees it
	logic [8:0]  pos_cnt;
	logic [7:0]  unit_addr;
	logic [7:0]  fcode;
	logic [7:0]  byte_count;
	logic [7:0]  hi_byte;
	logic [7:0]  exc_byte;
	logic [15:0] crc_acc;
	logic [7:0]  crc_dly0;
	logic [7:0]  crc_dly1;

	parse_result_t expected_results[$];
	parse_result_t oldest;

	int n_errors = 0;
	int n_bytes = 0;
	int n_frames = 0;
	int n_words = 0;
	int n_status = 0;
	int n_in_stalls = 0;
	int cycle_cnt = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	// bit-serial form of the reflected crc-16
	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic clear_frame();
		pos_cnt = '0;
		unit_addr = '0;
		fcode = '0;
		byte_count = '0;
		hi_byte = '0;
		exc_byte = '0;
		crc_acc = CRC_INIT;
		crc_dly0 = '0;
		crc_dly1 = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic is_last);
		int p;
		int len;
		logic [7:0] prev_low;
		logic word_out;
		int widx;
		logic [15:0] wval;
		parse_result_t r;
		p = int'(pos_cnt);
		prev_low = crc_dly0;
		word_out = 1'b0;
		widx = 0;
		wval = '0;
		if (p == 0) begin
			unit_addr = b;
		end else if (p == 1) begin
			fcode = b;
		end else if (p == 2) begin
			byte_count = b;
			exc_byte = b;
		end
		if (p < FRAME_LIMIT && p >= 3 && (fcode & EXC_BIT) == 8'h00) begin
			wval = {hi_byte, b};
			if (fcode == FC_READ_HOLDING) begin
				if (p >= 4 && p % 2 == 0 && (p - 4) / 2 < int'(byte_count >> 1)) begin
					word_out = 1'b1;
					widx = (p - 4) / 2;
				end
			end else if (fcode == FC_WRITE_SINGLE || fcode == FC_WRITE_MULTI) begin
				if (p == 3 || p == 5) begin
					word_out = 1'b1;
					widx = (p - 3) / 2;
				end
			end
		end
		hi_byte = b;
		// the crc trails the stream by two bytes so the received crc stays out
		if (p >= 2) begin
			crc_acc = crc16_update(crc_acc, crc_dly1);
		end
		crc_dly1 = crc_dly0;
		crc_dly0 = b;
		if (p < FRAME_LIMIT) begin
			pos_cnt = 9'(p + 1);
		end
		r = '0;
		r.addr = unit_addr;
		r.fcode = fcode;
		if (is_last) begin
			len = p + 1;
			r.kind = RK_STATUS;
			if (len > FRAME_LIMIT) begin
				r.status = ST_CRC_ERR;
			end else if (len < 5) begin
				r.status = ST_SHORT;
			end else if ((fcode & EXC_BIT) != 8'h00) begin
				r.status = ST_EXCEPT;
				r.exc = exc_byte;
			end else if (fcode == FC_READ_HOLDING && len < 5 + int'(byte_count)) begin
				r.status = ST_SHORT;
			end else if ((fcode == FC_WRITE_SINGLE || fcode == FC_WRITE_MULTI) && len < 7) begin
				r.status = ST_SHORT;
			end else if (fcode != FC_READ_HOLDING && fcode != FC_WRITE_SINGLE &&
					fcode != FC_WRITE_MULTI) begin
				r.status = ST_UNKNOWN;
			end else if (crc_acc != {b, prev_low}) begin
				r.status = ST_CRC_ERR;
			end else begin
				r.status = ST_OK;
			end
			expected_results.push_back(r);
			clear_frame();
		end else if (word_out) begin
			r.kind = RK_WORD;
			r.index = widx[6:0];
			r.value = wval;
			expected_results.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected, kind %0d", result_kind);
				n_errors++;
			end else begin
				oldest = expected_results.pop_front();
				check_field("result_kind", oldest.kind, result_kind);
				check_field("word_index", oldest.index, word_index);
				check_field("word_value", oldest.value, word_value);
				check_field("slave_address", oldest.addr, slave_address);
				check_field("function_code", oldest.fcode, function_code);
				check_field("frame_status", oldest.status, frame_status);
				check_field("exception_code", oldest.exc, exception_code);
				if (oldest.kind == RK_WORD) begin
					n_words++;
				end else begin
					n_status++;
				end
			end
		end
	end

	// result side stall, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (rx_valid && rx_stall) begin
			n_in_stalls++;
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[modbus_rtu_response_parser] ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		frame_last <= is_last;
		@(posedge clk);
		while (rx_stall) begin
			@(posedge clk);
		end
		predict_byte(b, is_last);
		n_bytes++;
	endtask

	task automatic send_frame(input frame_bytes_t f);
		for (int i = 0; i < f.size(); i++) begin
			send_byte(f[i], i == f.size() - 1);
		end
		n_frames++;
	endtask

	task automatic append_crc(inout frame_bytes_t f);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (f[i]) begin
			c = crc16_update(c, f[i]);
		end
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
	endtask

	task automatic add_random_bytes(inout frame_bytes_t f, input int n);
		for (int i = 0; i < n; i++) begin
			f.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic build_read_frame(output frame_bytes_t f);
		int sel;
		int cnt;
		sel = $urandom_range(99);
		if (sel < 80) begin
			cnt = $urandom_range(16);
		end else if (sel < 95) begin
			cnt = $urandom_range(60, 17);
		end else begin
			cnt = $urandom_range(255, 61);
		end
		f = {8'($urandom_range(255)), FC_READ_HOLDING, 8'(cnt)};
		add_random_bytes(f, cnt);
		append_crc(f);
	endtask

	task automatic build_write_frame(output frame_bytes_t f);
		f = {8'($urandom_range(255)), $urandom_range(1) ? FC_WRITE_SINGLE : FC_WRITE_MULTI};
		add_random_bytes(f, 4);
		append_crc(f);
	endtask

	task automatic build_random_frame(output frame_bytes_t f);
		int sel;
		int idx;
		sel = $urandom_range(99);
		if (sel < 35) begin
			build_read_frame(f);
		end else if (sel < 60) begin
			build_write_frame(f);
		end else if (sel < 70) begin
			f = {8'($urandom_range(255)), 8'($urandom_range(255)) | EXC_BIT};
			add_random_bytes(f, 3);
		end else if (sel < 78) begin
			f = {8'($urandom_range(255)), 8'($urandom_range(127))};
			add_random_bytes(f, $urandom_range(6, 1));
			append_crc(f);
		end else if (sel < 88) begin
			f = {};
			add_random_bytes(f, $urandom_range(12, 1));
		end else begin
			// a good frame that got damaged on the line
			if ($urandom_range(1)) begin
				build_read_frame(f);
			end else begin
				build_write_frame(f);
			end
			if ($urandom_range(1)) begin
				idx = $urandom_range(f.size() - 1);
				f[idx] = f[idx] ^ (8'h01 << $urandom_range(7));
			end else begin
				idx = $urandom_range(f.size() - 1, 1);
				while (f.size() > idx) begin
					f.delete(f.size() - 1);
				end
			end
		end
	endtask

	task automatic test_read_holding();
		frame_bytes_t f;
		f = {8'hFF, FC_READ_HOLDING, 8'h02, 8'hFF, 8'hFF};
		append_crc(f);
		send_frame(f);
		// byte count says four but only one word arrives
		f = {8'h00, FC_READ_HOLDING, 8'h04, 8'h00, 8'h00};
		send_frame(f);
	endtask

	task automatic test_write_echo();
		frame_bytes_t f;
		f = {8'h00, FC_WRITE_SINGLE, 8'h00, 8'h00, 8'hFF, 8'hFF};
		append_crc(f);
		send_frame(f);
		// corrupted crc on an otherwise valid echo
		f = {8'h11, FC_WRITE_MULTI, 8'h12, 8'h34, 8'h56, 8'h78};
		append_crc(f);
		f[7] = f[7] ^ 8'h80;
		send_frame(f);
	endtask

	task automatic test_exception_and_short();
		frame_bytes_t f;
		f = {8'h01, 8'h83, 8'h02, 8'hAA, 8'h55};
		send_frame(f);
		f = {8'hFF};
		send_frame(f);
		// the word would complete on the closing byte
		f = {8'h01, FC_WRITE_SINGLE, 8'h12, 8'h34};
		send_frame(f);
	endtask

	task automatic test_unknown_function();
		frame_bytes_t f;
		f = {8'h07, 8'h04, 8'h00};
		append_crc(f);
		send_frame(f);
	endtask

	task automatic test_overlong();
		frame_bytes_t f;
		f = {8'h42, FC_READ_HOLDING, 8'hFF};
		add_random_bytes(f, 262);
		append_crc(f);
		send_frame(f);
		// exactly at the limit, and one past it
		f = {8'h42, FC_WRITE_MULTI};
		add_random_bytes(f, FRAME_LIMIT - 4);
		append_crc(f);
		send_frame(f);
		f = {8'h42, FC_WRITE_MULTI};
		add_random_bytes(f, FRAME_LIMIT - 3);
		append_crc(f);
		send_frame(f);
	endtask

	task automatic test_random_traffic(input int idle_p, input int stall_p, input int count);
		frame_bytes_t f;
		int stop_at;
		idle_pct = idle_p;
		stall_pct = stall_p;
		stop_at = n_bytes + count;
		while (n_bytes < stop_at) begin
			build_random_frame(f);
			send_frame(f);
		end
	endtask

	task automatic test_output_hold();
		frame_bytes_t f;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 4; i++) begin
			f = {8'($urandom_range(255)), FC_READ_HOLDING, 8'd20};
			add_random_bytes(f, 20);
			append_crc(f);
			send_frame(f);
		end
	endtask

	initial begin
		clear_frame();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_holding();
		test_write_echo();
		test_exception_and_short();
		test_unknown_function();
		test_overlong();
		test_random_traffic(0, 0, RANDOM_BYTES);
		test_random_traffic(72, 0, RANDOM_BYTES);
		test_random_traffic(0, 72, RANDOM_BYTES);
		test_random_traffic(23, 23, RANDOM_BYTES);
		test_output_hold();
		rx_valid <= 1'b0;
		stall_pct = 10;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		$display("bytes sent %0d in %0d frames, input stall cycles %0d", n_bytes, n_frames,
			n_in_stalls);
		$display("register words checked %0d, frame statuses checked %0d", n_words, n_status);
		if (n_errors == 0) begin
			$display("[modbus_rtu_response_parser] OK");
		end else begin
			$display("[modbus_rtu_response_parser] ERROR");
		end
		$finish;
	end

endmodule

// ----- modbus_rtu_response_parser.f -----
rtl/core/mrp_pkg.sv
rtl/core/mrp_crc.sv
rtl/core/modbus_rtu_response_parser.sv
verif/tb_modbus_rtu_response_parser.sv
